>>> sv/bqs_pkg.sv
// Shared constants and stage-enable types for the biquadratic 3x3 sampler.
package bqs_pkg;

  localparam int FRAC_BITS_DEF = 8;   // fraction bits of frac_x and frac_y
  localparam int PIX_W         = 8;   // pixel width
  localparam int FRAC_W        = 8;   // width of the fraction ports
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // Load enables of the two column lane stages.
  typedef struct packed {
    logic s1;
    logic s2;
  } lane_en_t;

  // Load enables of the four merge stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } merge_en_t;

endpackage

>>> sv/bqs_lane.sv
// Column lane: quadratic through three pixels evaluated at 1 + frac_y.
module bqs_lane #(
  parameter int FRAC_BITS = bqs_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  bqs_pkg::lane_en_t              en,
  input  logic [bqs_pkg::PIX_W-1:0]      p0,
  input  logic [bqs_pkg::PIX_W-1:0]      p1,
  input  logic [bqs_pkg::PIX_W-1:0]      p2,
  input  logic [FRAC_BITS:0]             t,
  output logic signed [FRAC_BITS+9:0]    zq
);
  import bqs_pkg::*;

  localparam int TW  = FRAC_BITS + 1;
  localparam int UW  = FRAC_BITS + 12;
  localparam int ZSW = 2 * FRAC_BITS + 14;
  localparam int ZW  = FRAC_BITS + 10;

  logic [10:0]            e0, e1, e2;
  logic signed [9:0]      a;
  logic signed [10:0]     b;
  logic signed [TW:0]     t_s;
  logic signed [UW-1:0]   ta;
  logic signed [UW-1:0]   u_nxt;
  logic signed [UW-1:0]   u_r;
  logic [TW-1:0]          t_r;
  logic [PIX_W-1:0]       p0_r;
  logic signed [TW:0]     tr_s;
  logic signed [ZSW-1:0]  tu;
  logic signed [ZSW-1:0]  p0_term;
  logic signed [ZSW-1:0]  zs;
  logic signed [ZW-1:0]   zq_nxt;
  logic signed [ZW-1:0]   zq_r;

  // Coefficients of the quadratic; the sums wrap but the final values fit.
  assign e0 = {3'b000, p0};
  assign e1 = {3'b000, p1};
  assign e2 = {3'b000, p2};
  assign a  = e0[9:0] - (e1[9:0] << 1) + e2[9:0];
  assign b  = (e1 << 2) - (e0 << 1) - e0 - e2;

  assign t_s   = $signed({1'b0, t});
  assign ta    = t_s * a;
  assign u_nxt = ta + (UW'(b) <<< FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      u_r  <= u_nxt;
      t_r  <= t;
      p0_r <= p0;
    end
  end

  // Horner step, then floor division by 2^(FRAC_BITS+1) as an arithmetic shift.
  assign tr_s    = $signed({1'b0, t_r});
  assign tu      = tr_s * u_r;
  assign p0_term = $signed(ZSW'(p0_r)) <<< (2 * FRAC_BITS + 1);
  assign zs      = tu + p0_term;
  assign zq_nxt  = zs[ZW+FRAC_BITS:FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (en.s2) begin
      zq_r <= zq_nxt;
    end
  end

  assign zq = zq_r;

endmodule

>>> sv/bqs_merge.sv
// Merge stage: quadratic across the three column values, then truncate and clamp.
module bqs_merge #(
  parameter int FRAC_BITS = bqs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  bqs_pkg::merge_en_t            en,
  input  logic signed [FRAC_BITS+9:0]   z0,
  input  logic signed [FRAC_BITS+9:0]   z1,
  input  logic signed [FRAC_BITS+9:0]   z2,
  input  logic [FRAC_BITS:0]            tx,
  output logic [bqs_pkg::PIX_W-1:0]     sample
);
  import bqs_pkg::*;

  localparam int TW  = FRAC_BITS + 1;
  localparam int ZW  = FRAC_BITS + 10;
  localparam int AW  = FRAC_BITS + 12;
  localparam int BW  = FRAC_BITS + 13;
  localparam int U2W = 2 * FRAC_BITS + 14;
  localparam int H   = U2W / 2;
  localparam int HI  = U2W - H;
  localparam int NW  = 3 * FRAC_BITS + 15;
  localparam int SH  = 3 * FRAC_BITS + 1;
  localparam int QW  = NW - SH;

  logic signed [AW-1:0]      a;
  logic signed [BW-1:0]      b;
  logic signed [TW:0]        tx_s;
  logic signed [U2W-1:0]     ta;
  logic signed [U2W-1:0]     u2_nxt;
  logic signed [U2W-1:0]     u2_r;
  logic [TW-1:0]             tx1_r;
  logic signed [ZW-1:0]      z0_1_r;
  logic [H-1:0]              u2_lo;
  logic signed [HI-1:0]      u2_hi;
  logic signed [TW:0]        tx1_s;
  logic [TW+H-1:0]           pl_nxt;
  logic signed [TW+HI:0]     ph_nxt;
  logic [TW+H-1:0]           pl_r;
  logic signed [TW+HI:0]     ph_r;
  logic signed [ZW-1:0]      z0_2_r;
  logic signed [NW-1:0]      pl_ext;
  logic signed [NW-1:0]      ph_ext;
  logic signed [NW-1:0]      z_ext;
  logic signed [NW-1:0]      n_nxt;
  logic signed [NW-1:0]      n_r;
  logic [QW-1:0]             q;
  logic [PIX_W-1:0]          sample_nxt;
  logic [PIX_W-1:0]          sample_r;

  // First stage: inner Horner term tx*A + S*B.
  assign a      = AW'(z0) - (AW'(z1) <<< 1) + AW'(z2);
  assign b      = (BW'(z1) <<< 2) - (BW'(z0) <<< 1) - BW'(z0) - BW'(z2);
  assign tx_s   = $signed({1'b0, tx});
  assign ta     = tx_s * a;
  assign u2_nxt = ta + (U2W'(b) <<< FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      u2_r   <= u2_nxt;
      tx1_r  <= tx;
      z0_1_r <= z0;
    end
  end

  // Second stage: the wide product tx*u2 as two partial products.
  assign u2_lo  = u2_r[H-1:0];
  assign u2_hi  = u2_r[U2W-1:H];
  assign tx1_s  = $signed({1'b0, tx1_r});
  assign pl_nxt = tx1_r * u2_lo;
  assign ph_nxt = tx1_s * u2_hi;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      pl_r   <= pl_nxt;
      ph_r   <= ph_nxt;
      z0_2_r <= z0_1_r;
    end
  end

  // Third stage: recombine the partial products and add the constant term.
  assign pl_ext = NW'(pl_r);
  assign ph_ext = NW'(ph_r);
  assign z_ext  = NW'(z0_2_r);
  assign n_nxt  = (ph_ext <<< H) + pl_ext + (z_ext <<< (2 * FRAC_BITS + 1));

  always_ff @(posedge clk) begin
    if (en.s3) begin
      n_r <= n_nxt;
    end
  end

  // Last stage: a non-positive sum gives zero, anything above the pixel range saturates.
  assign q = n_r[NW-1:SH];

  always_comb begin
    if (n_r[NW-1] || (n_r == '0)) begin
      sample_nxt = '0;
    end else if (|q[QW-1:PIX_W]) begin
      sample_nxt = PIX_MAX;
    end else begin
      sample_nxt = q[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      sample_r <= sample_nxt;
    end
  end

  assign sample = sample_r;

endmodule

>>> sv/biquadratic_sample_3x3.sv
// Top level of the biquadratic 3x3 sampler: three column lanes, merge stage, flow control.
//
//   channel   ports                                       direction   flow control
//   in        in_up_left .. in_down_right, in_frac_x/y    in          in_valid / in_stall
//   out       out_sample_out                              out         out_valid / out_stall
//
// One word is accepted per clock while in_stall is low; out_valid rises when it reaches the last register stage.
// The pipeline is six register stages: two in the column lanes, four in the merge stage.
// Each stage loads when it is empty or when the stage after it moves, so bubbles are
// squeezed out while out_stall holds the output word.
// rst_n is synchronous and clears only the stage valid bits.
module biquadratic_sample_3x3 #(
  parameter int FRAC_BITS = bqs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bqs_pkg::PIX_W-1:0]   in_up_left,
  input  logic [bqs_pkg::PIX_W-1:0]   in_up_mid,
  input  logic [bqs_pkg::PIX_W-1:0]   in_up_right,
  input  logic [bqs_pkg::PIX_W-1:0]   in_mid_left,
  input  logic [bqs_pkg::PIX_W-1:0]   in_center_pixel,
  input  logic [bqs_pkg::PIX_W-1:0]   in_mid_right,
  input  logic [bqs_pkg::PIX_W-1:0]   in_down_left,
  input  logic [bqs_pkg::PIX_W-1:0]   in_down_mid,
  input  logic [bqs_pkg::PIX_W-1:0]   in_down_right,
  input  logic [bqs_pkg::FRAC_W-1:0]  in_frac_x,
  input  logic [bqs_pkg::FRAC_W-1:0]  in_frac_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bqs_pkg::PIX_W-1:0]   out_sample_out
);
  import bqs_pkg::*;

  localparam int NSTG = 6;

  logic [NSTG-1:0]         vld_r;
  logic [NSTG-1:0]         vld_nxt;
  logic [NSTG-1:0]         rdy;
  logic [FRAC_BITS:0]      fx_ext;
  logic [FRAC_BITS:0]      fy_ext;
  logic [FRAC_BITS:0]      tx;
  logic [FRAC_BITS:0]      ty;
  logic [FRAC_BITS:0]      tx1_r;
  logic [FRAC_BITS:0]      tx2_r;
  lane_en_t                lane_en;
  merge_en_t               merge_en;
  logic signed [FRAC_BITS+9:0] z0;
  logic signed [FRAC_BITS+9:0] z1;
  logic signed [FRAC_BITS+9:0] z2;

  // Fraction bits at or above FRAC_BITS are dropped; t = 1 + frac in Q1.FRAC_BITS.
  assign fx_ext = (FRAC_BITS + 1)'(in_frac_x);
  assign fy_ext = (FRAC_BITS + 1)'(in_frac_y);
  assign tx     = {1'b1, fx_ext[FRAC_BITS-1:0]};
  assign ty     = {1'b1, fy_ext[FRAC_BITS-1:0]};

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NSTG; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // frac_x travels beside the column lanes until the merge stage needs it.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      tx1_r <= tx;
    end
    if (rdy[1]) begin
      tx2_r <= tx1_r;
    end
  end

  assign lane_en  = '{s1: rdy[0], s2: rdy[1]};
  assign merge_en = '{s1: rdy[2], s2: rdy[3], s3: rdy[4], s4: rdy[5]};

  bqs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_left (
    .clk (clk),
    .en  (lane_en),
    .p0  (in_up_left),
    .p1  (in_mid_left),
    .p2  (in_down_left),
    .t   (ty),
    .zq  (z0)
  );

  bqs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_mid (
    .clk (clk),
    .en  (lane_en),
    .p0  (in_up_mid),
    .p1  (in_center_pixel),
    .p2  (in_down_mid),
    .t   (ty),
    .zq  (z1)
  );

  bqs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_right (
    .clk (clk),
    .en  (lane_en),
    .p0  (in_up_right),
    .p1  (in_mid_right),
    .p2  (in_down_right),
    .t   (ty),
    .zq  (z2)
  );

  bqs_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk    (clk),
    .en     (merge_en),
    .z0     (z0),
    .z1     (z1),
    .z2     (z2),
    .tx     (tx2_r),
    .sample (out_sample_out)
  );

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NSTG-1];

endmodule

>>> verif/tb_biquadratic_sample_3x3.sv
// Self-checking testbench for the biquadratic 3x3 sampler with a bit-exact predictor.
`timescale 1ns / 1ps

localparam int SAMPLE_FB = bqs_pkg::FRAC_BITS_DEF;

typedef struct packed {
  logic [8:0][bqs_pkg::PIX_W-1:0] pix;  // up_left at index 0 .. down_right at index 8
  logic [bqs_pkg::FRAC_W-1:0]     frac_x;
  logic [bqs_pkg::FRAC_W-1:0]     frac_y;
} pix_word_t;

class sample_scoreboard;
  logic [bqs_pkg::PIX_W-1:0] expected_q[$];
  pix_word_t                 source_q[$];
  int errors;
  int n_in;
  int n_checked;
  int n_sat_high;
  int n_sat_low;

  function new();
    errors     = 0;
    n_in       = 0;
    n_checked  = 0;
    n_sat_high = 0;
    n_sat_low  = 0;
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Quadratic through nodes 0, 1, 2 evaluated at t (Q1.FB), scaled by 2*S^2.
  function longint quad_at(longint p0, longint p1, longint p2, longint t);
    longint one;
    longint a;
    longint b;
    one = longint'(1) <<< SAMPLE_FB;
    a   = p0 - 2 * p1 + p2;
    b   = -3 * p0 + 4 * p1 - p2;
    return t * t * a + t * one * b + 2 * one * one * p0;
  endfunction

  function logic [bqs_pkg::PIX_W-1:0] interp_sample(pix_word_t w);
    longint one;
    longint fmask;
    longint tx;
    longint ty;
    longint col[3];
    longint n;
    longint r;
    one   = longint'(1) <<< SAMPLE_FB;
    fmask = one - 1;
    tx    = one + (longint'(w.frac_x) & fmask);
    ty    = one + (longint'(w.frac_y) & fmask);
    for (int c = 0; c < 3; c++) begin
      // Arithmetic shift of a signed value rounds toward minus infinity.
      col[c] = quad_at(longint'(w.pix[c]), longint'(w.pix[c + 3]),
                       longint'(w.pix[c + 6]), ty) >>> (SAMPLE_FB + 1);
    end
    n = quad_at(col[0], col[1], col[2], tx);
    if (n <= 0) begin
      return '0;
    end
    r = n >>> (3 * SAMPLE_FB + 1);
    if (r > 255) begin
      return bqs_pkg::PIX_MAX;
    end
    return r[bqs_pkg::PIX_W-1:0];
  endfunction

  function void note_word(pix_word_t w);
    logic [bqs_pkg::PIX_W-1:0] e;
    e = interp_sample(w);
    if (e == bqs_pkg::PIX_MAX) n_sat_high++;
    if (e == '0) n_sat_low++;
    expected_q.push_back(e);
    source_q.push_back(w);
    n_in++;
  endfunction

  task check_result(logic [bqs_pkg::PIX_W-1:0] got);
    logic [bqs_pkg::PIX_W-1:0] e;
    pix_word_t w;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("sample %0d arrived with no word pending", got));
      return;
    end
    e = expected_q.pop_front();
    w = source_q.pop_front();
    n_checked++;
    if (got !== e) begin
      report_mismatch($sformatf("sample_out %0d, predicted %0d (pix %h fx %h fy %h)",
                                got, e, w.pix, w.frac_x, w.frac_y));
    end
  endtask

  function int pending();
    return expected_q.size();
  endfunction

  task final_check();
    if (expected_q.size() != 0) begin
      report_mismatch($sformatf("%0d predicted samples never arrived", expected_q.size()));
    end
  endtask
endclass

module tb_biquadratic_sample_3x3;
  localparam int IDLE_LIMIT = 5000;
  localparam int N_RANDOM   = 750;
  localparam int DRAIN_WAIT = 20;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic out_valid;
  logic out_stall;
  logic [bqs_pkg::PIX_W-1:0] out_sample_out;
  pix_word_t drv;

  sample_scoreboard sb;
  pix_word_t directed_q[$];
  int idle_cycles;
  int stall_mode;
  int phase_left;
  int hold_left;
  int burst_left;

  biquadratic_sample_3x3 #(
    .FRAC_BITS(SAMPLE_FB)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_up_left     (drv.pix[0]),
    .in_up_mid      (drv.pix[1]),
    .in_up_right    (drv.pix[2]),
    .in_mid_left    (drv.pix[3]),
    .in_center_pixel(drv.pix[4]),
    .in_mid_right   (drv.pix[5]),
    .in_down_left   (drv.pix[6]),
    .in_down_mid    (drv.pix[7]),
    .in_down_right  (drv.pix[8]),
    .in_frac_x      (drv.frac_x),
    .in_frac_y      (drv.frac_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic pix_word_t grid(int ul, int um, int ur, int ml, int c, int mr,
                                     int dl, int dm, int dr, int fx, int fy);
    pix_word_t w;
    w.pix[0] = ul[7:0]; w.pix[1] = um[7:0]; w.pix[2] = ur[7:0];
    w.pix[3] = ml[7:0]; w.pix[4] = c[7:0];  w.pix[5] = mr[7:0];
    w.pix[6] = dl[7:0]; w.pix[7] = dm[7:0]; w.pix[8] = dr[7:0];
    w.frac_x = fx[7:0];
    w.frac_y = fy[7:0];
    return w;
  endfunction

  function automatic logic [7:0] edge_frac();
    int k;
    k = $urandom_range(0, 3);
    case (k)
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'hFE;
      default: return 8'hFF;
    endcase
  endfunction

  // Mix of uniform noise, smooth patches, hard edges of 0 and 255 pixels, and extreme fractions.
  function automatic pix_word_t random_word();
    pix_word_t w;
    int kind;
    int base;
    int v;
    kind = $urandom_range(0, 9);
    base = $urandom_range(0, 255);
    for (int i = 0; i < 9; i++) begin
      if (kind < 4) begin
        w.pix[i] = 8'($urandom_range(0, 255));
      end else if (kind < 7) begin
        v = base + $urandom_range(0, 48) - 24;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        w.pix[i] = v[7:0];
      end else if (kind < 9) begin
        w.pix[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        w.pix[i] = 8'($urandom_range(0, 255));
      end
    end
    w.frac_x = (kind == 9) ? edge_frac() : 8'($urandom_range(0, 255));
    w.frac_y = (kind == 9) ? edge_frac() : 8'($urandom_range(0, 255));
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input pix_word_t w);
    drv      = w;
    in_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid = 1'b0;
      drv      = random_word();
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_with_bursts(input pix_word_t w);
    if (burst_left == 0) begin
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      burst_left = $urandom_range(1, 40);
    end
    send_word(w);
    burst_left--;
  endtask

  // Receiver stall pattern: modes of random length, from never stalling to long holds.
  always @(negedge clk) begin
    if (phase_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      phase_left = $urandom_range(50, 200);
    end
    phase_left--;
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = 1'($urandom_range(0, 1));
      2: out_stall = ($urandom_range(0, 7) == 0);
      default: begin
        if (hold_left == 0) begin
          out_stall = ~out_stall;
          hold_left = $urandom_range(3, 40);
        end else begin
          hold_left--;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_word(drv);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_sample_out);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    out_stall   = 1'b0;
    drv         = '0;
    idle_cycles = 0;
    stall_mode  = 0;
    phase_left  = 0;
    hold_left   = 0;
    burst_left  = 0;

    // Flat fields, the center peak, column and row overshoot, negative undershoot.
    directed_q.push_back(grid(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(grid(255, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255));
    directed_q.push_back(grid(255, 255, 255, 255, 255, 255, 255, 255, 255, 0, 0));
    directed_q.push_back(grid(0, 0, 0, 0, 255, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(grid(0, 0, 0, 0, 255, 0, 0, 0, 0, 128, 128));
    directed_q.push_back(grid(0, 0, 0, 255, 255, 255, 255, 255, 255, 0, 255));
    directed_q.push_back(grid(0, 0, 0, 255, 255, 255, 255, 255, 255, 255, 255));
    directed_q.push_back(grid(255, 255, 255, 0, 0, 0, 0, 0, 0, 128, 128));
    directed_q.push_back(grid(0, 255, 255, 0, 255, 255, 0, 255, 255, 255, 0));
    directed_q.push_back(grid(255, 0, 0, 255, 0, 0, 255, 0, 0, 200, 0));
    directed_q.push_back(grid(255, 0, 0, 255, 0, 0, 255, 0, 0, 200, 255));
    directed_q.push_back(grid(0, 255, 0, 255, 0, 255, 0, 255, 0, 8'h55, 8'h55));
    directed_q.push_back(grid(255, 0, 255, 0, 255, 0, 255, 0, 255, 8'hAA, 8'hAA));
    directed_q.push_back(grid(255, 255, 255, 255, 0, 255, 255, 255, 255, 128, 128));
    directed_q.push_back(grid(0, 0, 0, 128, 128, 128, 255, 255, 255, 1, 254));
    directed_q.push_back(grid(0, 128, 255, 0, 128, 255, 0, 128, 255, 254, 1));
    directed_q.push_back(grid(8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55,
                              8'h55, 8'hAA, 8'h55));
    directed_q.push_back(grid(8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA,
                              8'hAA, 8'h55, 8'hAA));
    directed_q.push_back(grid(10, 200, 30, 240, 5, 250, 20, 180, 60, 128, 0));
    directed_q.push_back(grid(10, 200, 30, 240, 5, 250, 20, 180, 60, 0, 128));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_q[i]) begin
      send_with_bursts(directed_q[i]);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      send_with_bursts(random_word());
    end
    in_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    sb.final_check();

    $display("Sent %0d words (%0d directed), checked %0d samples.",
             sb.n_in, directed_q.size(), sb.n_checked);
    $display("Predicted %0d samples saturated at 255 and %0d at 0.",
             sb.n_sat_high, sb.n_sat_low);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
